// ----- src/rc4_pkg.sv -----
package rc4_pkg;

  localparam int KeyBytes  = 64;
  localparam int KeyAw     = $clog2(KeyBytes);
  localparam int KeyLenW   = 7;
  localparam int ByteW     = 8;
  localparam int SboxDepth = 256;
  localparam int SboxAw    = $clog2(SboxDepth);

  localparam logic [KeyLenW-1:0] KeyLenReset = 7'd16;

  localparam logic OpKeyWrite = 1'b0;
  localparam logic OpCipher   = 1'b1;

endpackage

// ----- src/rc4_if.sv -----
// Input beat: key write or data byte.
interface rc4_in_if;
  import rc4_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [KeyAw-1:0] key_index;
  logic [ByteW-1:0] key_value;
  logic [ByteW-1:0] data_byte;
  logic             first_byte;
  logic             last_byte;

  modport source (
    output valid, op, key_index, key_value, data_byte, first_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, op, key_index, key_value, data_byte, first_byte, last_byte,
    output ready
  );
endinterface

// Output beat: ciphered byte.
interface rc4_out_if;
  import rc4_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_out;
  logic             last_out;

  modport source (
    output valid, data_out, last_out,
    input  ready
  );
  modport sink (
    input  valid, data_out, last_out,
    output ready
  );
endinterface

// ----- src/rc4_stream_cipher.sv -----
// RC4 cipher engine. Key bytes go into a 64-entry key store through input
// beats with op = 0 (no result); key_length (1..64, 0 acts as 1, larger
// values clamp to 64) sets how many of them the key schedule cycles
// through. A data beat (op = 1) gives one output beat: data XOR keystream, with
// last_out copied from last_byte. A data beat with first_byte set first reruns
// the schedule: an identity fill of the S-box, then 256 swap steps, each
// through StKRd, StKJ, StKWn and StKWj. A plain data byte passes through
// StG0 to StG3 before its output beat, as the S-box memory has a single read
// and a single write port. One item is in flight at a time: the engine goes
// back to idle once the result sits in the output register, and only there
// takes the next input beat. While the output register still holds an untaken
// beat the engine waits in its last step and takes no input. After reset the
// S-box is loaded with the identity in a sweep during which no input beat is
// accepted. Encrypt and decrypt are the same operation. Write key_length only
// while the engine is idle.
module rc4_stream_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::KeyLenW-1:0]   cfg_wdata_i,
  rc4_in_if.sink                        in_i,
  rc4_out_if.source                     out_o
);
  import rc4_pkg::*;

  // Sequencer states
  localparam logic [3:0] StInit = 4'd0;  // power-up identity fill
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StKFil = 4'd2;  // schedule: identity fill
  localparam logic [3:0] StKRd  = 4'd3;  // schedule: read S[n], K[n % len]
  localparam logic [3:0] StKJ   = 4'd4;  // schedule: new j, read S[j]
  localparam logic [3:0] StKWn  = 4'd5;  // schedule: S[n] <= S[j]
  localparam logic [3:0] StKWj  = 4'd6;  // schedule: S[j] <= S[n]
  localparam logic [3:0] StG0   = 4'd7;  // keystream: read S[i+1]
  localparam logic [3:0] StG1   = 4'd8;  // keystream: new j, read S[j]
  localparam logic [3:0] StG2   = 4'd9;  // keystream: S[i] <= S[j], read S[t]
  localparam logic [3:0] StG3   = 4'd10; // keystream: S[j] <= S[i], emit

  logic [3:0]         state_q, state_d;
  logic [SboxAw-1:0]  n_q, n_d;
  logic [KeyAw-1:0]   kidx_q, kidx_d;
  logic [SboxAw-1:0]  i_q, i_d;
  logic [SboxAw-1:0]  j_q, j_d;
  logic [ByteW-1:0]   si_q, si_d;
  logic [ByteW-1:0]   sj_q, sj_d;
  logic               fwd_i_q, fwd_i_d;
  logic               fwd_j_q, fwd_j_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic               last_q, last_d;
  logic [KeyLenW-1:0] key_len_q;

  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  // S-box memory port
  logic              s_we, s_re;
  logic [SboxAw-1:0] s_waddr, s_raddr;
  logic [ByteW-1:0]  s_wdata, s_rdata;

  // Key store port
  logic              k_we, k_re;
  logic [KeyAw-1:0]  k_waddr, k_raddr;
  logic [ByteW-1:0]  k_wdata, k_rdata;

  logic               in_acc;
  logic               out_free;
  logic [KeyLenW-1:0] eff_len;
  logic [KeyLenW-1:0] kidx_inc;
  logic [SboxAw-1:0]  t_addr;
  logic [ByteW-1:0]   ks_byte;

  rc4_ram #(.Width(ByteW), .Depth(SboxDepth)) u_sbox (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rc4_ram #(.Width(ByteW), .Depth(KeyBytes)) u_key (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Zero acts as one, anything past the store clamps to its size.
  always_comb begin
    if (key_len_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_len_q > KeyLenW'(KeyBytes)) begin
      eff_len = KeyLenW'(KeyBytes);
    end else begin
      eff_len = key_len_q;
    end
  end

  assign kidx_inc = {1'b0, kidx_q} + KeyLenW'(1);
  assign t_addr   = si_q + s_rdata;
  assign ks_byte  = fwd_i_q ? sj_q : (fwd_j_q ? si_q : s_rdata);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    fwd_i_d     = fwd_i_q;
    fwd_j_d     = fwd_j_q;
    data_d      = data_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    s_we    = 1'b0;
    s_waddr = n_q;
    s_wdata = n_q;
    s_re    = 1'b0;
    s_raddr = n_q;
    k_we    = 1'b0;
    k_waddr = in_i.key_index;
    k_wdata = in_i.key_value;
    k_re    = 1'b0;
    k_raddr = kidx_q;

    case (state_q)
      StInit, StKFil: begin
        s_we = 1'b1;
        n_d  = n_q + SboxAw'(1);
        if (n_q == '1) begin
          state_d = (state_q == StInit) ? StIdle : StKRd;
        end
      end
      StIdle: begin
        if (in_acc) begin
          if (in_i.op == OpKeyWrite) begin
            k_we = ({1'b0, in_i.key_index} < (KeyAw + 1)'(KeyBytes));
          end else begin
            data_d = in_i.data_byte;
            last_d = in_i.last_byte;
            if (in_i.first_byte) begin
              n_d     = '0;
              j_d     = '0;
              kidx_d  = '0;
              state_d = StKFil;
            end else begin
              state_d = StG0;
            end
          end
        end
      end
      StKRd: begin
        s_re    = 1'b1;
        k_re    = 1'b1;
        state_d = StKJ;
      end
      StKJ: begin
        si_d    = s_rdata;
        j_d     = j_q + s_rdata + k_rdata;
        s_re    = 1'b1;
        s_raddr = j_d;
        state_d = StKWn;
      end
      StKWn: begin
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = s_rdata;
        state_d = StKWj;
      end
      StKWj: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        n_d     = n_q + SboxAw'(1);
        kidx_d  = (kidx_inc >= eff_len) ? '0 : kidx_inc[KeyAw-1:0];
        if (n_q == '1) begin
          i_d     = '0;
          j_d     = '0;
          state_d = StG0;
        end else begin
          state_d = StKRd;
        end
      end
      StG0: begin
        i_d     = i_q + SboxAw'(1);
        s_re    = 1'b1;
        s_raddr = i_d;
        state_d = StG1;
      end
      StG1: begin
        si_d    = s_rdata;
        j_d     = j_q + s_rdata;
        s_re    = 1'b1;
        s_raddr = j_d;
        state_d = StG2;
      end
      StG2: begin
        // S[i] is overwritten and S[j] is still stale this cycle: forward.
        sj_d    = s_rdata;
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        s_re    = 1'b1;
        s_raddr = t_addr;
        fwd_i_d = (t_addr == i_q);
        fwd_j_d = (t_addr == j_q);
        state_d = StG3;
      end
      StG3: begin
        if (out_free) begin
          s_we        = 1'b1;
          s_waddr     = j_q;
          s_wdata     = si_q;
          out_valid_d = 1'b1;
          out_data_d  = data_q ^ ks_byte;
          out_last_d  = last_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      n_q         <= '0;
      kidx_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      key_len_q   <= KeyLenReset;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_len_q <= cfg_wdata_i;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    fwd_i_q    <= fwd_i_d;
    fwd_j_q    <= fwd_j_d;
    data_q     <= data_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.last_out = out_last_q;

endmodule

// ----- src/rc4_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rc4_checker.sv -----
module rc4_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      in_op_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [rc4_pkg::ByteW-1:0] out_data_i,
  input  logic                      out_last_i
);
  import rc4_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_data_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  // A key write never makes a beat
  a_key_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OpKeyWrite && !out_valid_i |=> !out_valid_i)
    else $error("key write produced an output beat");

  // A data byte keeps the engine busy in the cycle after it is taken
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OpCipher |=> !in_ready_i)
    else $error("input taken while a data byte is in flight");

  // No beat can be ready the cycle right after a data byte arrives
  a_data_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OpCipher && !out_valid_i |=> !out_valid_i)
    else $error("output beat appeared too early");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data_out),
  .out_last_i  (out_o.last_out)
);

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  // Clock half period in ns; watchdog and settle times in cycles of the 20 ns clock.
  localparam int ClkHalf      = 10;
  // A first byte waits for the whole key schedule, plus output stalls and
  // the S-box sweep after reset; the limit leaves a wide margin over these.
  localparam int QuietLimit   = 20000;
  // Key writes give no beat, so let the engine finish before touching
  // key_length or ending the run.
  localparam int SettleCycles = 20;
  localparam int MaxPrinted   = 200;
  localparam int NumPhases    = 8;
  localparam int PhaseBeats   = 180;

  // One expected output beat.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cipher_beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [KeyLenW-1:0] cfg_wdata;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // ---------------------------------------------------------------------
  // Cipher predictor: private copy of S-box, indices, key store, length.
  // ---------------------------------------------------------------------
  logic [ByteW-1:0]   sbox_m [SboxDepth];
  logic [ByteW-1:0]   idx_i_m;
  logic [ByteW-1:0]   idx_j_m;
  logic [ByteW-1:0]   key_mem [KeyBytes];
  bit                 key_loaded [KeyBytes];
  logic [KeyLenW-1:0] key_len_m;

  cipher_beat_t cipher_q [$];   // expected output beats, oldest first

  int unsigned mismatches;
  int unsigned beats_sent;      // input beats accepted so far
  int unsigned beats_checked;   // output beats seen so far
  int unsigned quiet_cycles;
  int unsigned send_gap_pct;    // chance per cycle that the sender idles
  int unsigned sink_stall_pct;  // chance per cycle that ready is low

  function automatic void reset_model();
    int n;
    for (n = 0; n < SboxDepth; n++) begin
      sbox_m[n]     = ByteW'(n);
    end
    for (n = 0; n < KeyBytes; n++) begin
      key_mem[n]    = '0;
      key_loaded[n] = 1'b0;
    end
    idx_i_m   = '0;
    idx_j_m   = '0;
    key_len_m = KeyLenReset;
  endfunction

  // Zero acts as one, anything past the store clamps to the store size.
  function automatic int unsigned used_key_bytes();
    if (key_len_m == '0) begin
      return 1;
    end
    if (key_len_m > KeyBytes) begin
      return KeyBytes;
    end
    return key_len_m;
  endfunction

  // Full key schedule: identity fill, then 256 key-driven swaps.
  function automatic void run_key_schedule();
    int unsigned      len;
    int               n;
    logic [ByteW-1:0] j;
    logic [ByteW-1:0] t;
    len = used_key_bytes();
    j   = '0;
    for (n = 0; n < SboxDepth; n++) begin
      sbox_m[n] = ByteW'(n);
    end
    for (n = 0; n < SboxDepth; n++) begin
      j         = j + sbox_m[n] + key_mem[n % len];
      t         = sbox_m[n];
      sbox_m[n] = sbox_m[j];
      sbox_m[j] = t;
    end
    idx_i_m = '0;
    idx_j_m = '0;
  endfunction

  // One generator step: advance i, j, swap, return the keystream byte.
  function automatic logic [ByteW-1:0] keystream_step();
    logic [ByteW-1:0] i;
    logic [ByteW-1:0] j;
    logic [ByteW-1:0] t;
    i         = idx_i_m + 1'b1;
    j         = idx_j_m + sbox_m[i];
    t         = sbox_m[i];
    sbox_m[i] = sbox_m[j];
    sbox_m[j] = t;
    idx_i_m   = i;
    idx_j_m   = j;
    t         = sbox_m[i] + sbox_m[j];
    return sbox_m[t];
  endfunction

  // Apply one accepted input beat. The key index is 6 bits wide, so it
  // always lands inside the 64-entry store.
  function automatic void predict_beat(input logic             op,
                                       input logic [KeyAw-1:0] kidx,
                                       input logic [ByteW-1:0] kval,
                                       input logic [ByteW-1:0] data,
                                       input logic             first,
                                       input logic             last);
    cipher_beat_t beat;
    if (op == OpKeyWrite) begin
      key_mem[kidx]    = kval;
      key_loaded[kidx] = 1'b1;
      return;
    end
    if (first) begin
      run_key_schedule();
    end
    beat.data = data ^ keystream_step();
    beat.last = last;
    cipher_q.push_back(beat);
  endfunction

  // ---------------------------------------------------------------------
  // Clock, sink ready, result checking, watchdog.
  // ---------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #ClkHalf;
    clk_i = 1'b1;
    #ClkHalf;
  end

  // Sink side: ready changes only on the falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t mismatch at output beat %0d: %s", $time, beats_checked, what);
    end
  endtask

  // Every output beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    cipher_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected, data %02h last %0b",
                                  out_if.data_out, out_if.last_out));
      end else begin
        want = cipher_q.pop_front();
        if (out_if.data_out !== want.data) begin
          report_mismatch($sformatf("data_out %02h, expected %02h",
                                    out_if.data_out, want.data));
        end
        if (out_if.last_out !== want.last) begin
          report_mismatch($sformatf("last_out %0b, expected %0b",
                                    out_if.last_out, want.last));
        end
      end
      beats_checked++;
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no beat for %0d cycles", QuietLimit);
      $display("rc4_stream_cipher regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Drive one input beat from a falling edge, hold it until accepted, and
  // return on the next falling edge with valid still high.
  task automatic send_beat(input logic             op,
                           input logic [KeyAw-1:0] kidx,
                           input logic [ByteW-1:0] kval,
                           input logic [ByteW-1:0] data,
                           input logic             first,
                           input logic             last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.op         <= op;
    in_if.key_index  <= kidx;
    in_if.key_value  <= kval;
    in_if.data_byte  <= data;
    in_if.first_byte <= first;
    in_if.last_byte  <= last;
    in_if.valid      <= 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_beat(op, kidx, kval, data, first, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Key write; data, first and last carry noise.
  task automatic send_key(input logic [KeyAw-1:0] kidx, input logic [ByteW-1:0] kval);
    send_beat(OpKeyWrite, kidx, kval, ByteW'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Data byte; key index and value carry noise.
  task automatic send_data(input logic [ByteW-1:0] data, input logic first,
                           input logic last);
    send_beat(OpCipher, KeyAw'($urandom), ByteW'($urandom), data, first, last);
  endtask

  // Sender holds off until every expected beat has come out.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (cipher_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // key_length only changes on an idle engine.
  task automatic set_key_length(input logic [KeyLenW-1:0] len);
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    key_len_m = len;
  endtask

  // The schedule must never read a key byte that was never loaded.
  task automatic cover_keys();
    int unsigned n;
    for (n = 0; n < used_key_bytes(); n++) begin
      if (!key_loaded[n]) begin
        send_key(KeyAw'(n), ByteW'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Bytes straight after reset use the identity S-box, no schedule yet.
  // The key write in between hits the top of the store with 0xff.
  task automatic test_before_schedule();
    send_data(8'h00, 1'b0, 1'b0);
    send_key(KeyAw'(KeyBytes - 1), 8'hff);
    send_data(8'hff, 1'b0, 1'b1);
  endtask

  // Short packets at the reset length, length one, zero (acts as one),
  // the full store and an overlong value that clamps.
  task automatic test_key_lengths();
    logic [KeyLenW-1:0] lens [5];
    int                 k;
    lens = '{KeyLenReset, 7'd1, 7'd0, 7'd64, 7'd127};
    send_key('0, 8'h00);
    for (k = 0; k < 5; k++) begin
      if (k != 0) begin
        set_key_length(lens[k]);
      end
      cover_keys();
      send_data(8'h00, 1'b1, 1'b0);
      send_data(8'hff, 1'b0, 1'b0);
      send_data(ByteW'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Packet framing corners and a decrypt of freshly encrypted bytes.
  task automatic test_packet_edges();
    logic [ByteW-1:0] plain  [3];
    logic [ByteW-1:0] sealed [3];
    int               n;
    send_data(ByteW'($urandom), 1'b1, 1'b1);          // one-byte packet
    send_data(ByteW'($urandom), 1'b1, 1'b0);
    // key write inside a packet, with first and last set on it
    send_beat(OpKeyWrite, KeyAw'(5), ByteW'($urandom), ByteW'($urandom), 1'b1, 1'b1);
    send_data(ByteW'($urandom), 1'b0, 1'b1);
    send_data(ByteW'($urandom), 1'b0, 1'b0);          // byte after last, no first
    for (n = 0; n < 3; n++) begin
      plain[n] = ByteW'($urandom);
      send_data(plain[n], n == 0, n == 2);
      sealed[n] = cipher_q[$].data;
    end
    // same key, restarted schedule: ciphertext in, plaintext out
    for (n = 0; n < 3; n++) begin
      send_data(sealed[n], n == 0, n == 2);
    end
  endtask

  // Mostly well-formed packets with random payload, some rekeying, and a
  // share of continuation bytes, stray key writes and random framing.
  task automatic run_phase(input int unsigned n_beats, input int unsigned gap_pct,
                           input int unsigned stall_pct, input logic [KeyLenW-1:0] len);
    int unsigned start;
    int unsigned pick;
    int unsigned plen;
    int unsigned n;
    bit          paused;
    set_key_length(len);
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    cover_keys();
    start  = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3)) send_key(KeyAw'($urandom), ByteW'($urandom));
        end
        plen = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 60);
        for (n = 0; n < plen; n++) begin
          send_data(ByteW'($urandom), n == 0, n == plen - 1);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_data(ByteW'($urandom), 1'b0, 1'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_key(KeyAw'($urandom), ByteW'($urandom));
      end else begin
        send_data(ByteW'($urandom), 1'($urandom), 1'($urandom));
      end
      // halfway through, the sender stops until the output has caught up
      if (!paused && beats_sent - start >= n_beats / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Idle modes cycle through none, sender gaps, sink stalls, both.
  task automatic test_random_traffic();
    int unsigned        gaps   [4];
    int unsigned        stalls [4];
    logic [KeyLenW-1:0] lens   [NumPhases];
    int                 p;
    gaps   = '{0, 47, 0, 14};
    stalls = '{0, 0, 47, 14};
    lens   = '{7'd64, 7'd1, 7'd0, 7'd127, KeyLenReset,
               KeyLenW'($urandom_range(2, KeyBytes - 1)), 7'd5,
               KeyLenW'($urandom_range(2, KeyBytes - 1))};
    for (p = 0; p < NumPhases; p++) begin
      run_phase(PhaseBeats, gaps[p % 4], stalls[p % 4], lens[p]);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.op         = OpKeyWrite;
    in_if.key_index  = '0;
    in_if.key_value  = '0;
    in_if.data_byte  = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    send_gap_pct     = 0;
    sink_stall_pct   = 0;
    mismatches       = 0;
    beats_sent       = 0;
    beats_checked    = 0;
    quiet_cycles     = 0;
    reset_model();

    // reset held low at the start, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_before_schedule();
    test_key_lengths();
    test_packet_edges();
    test_random_traffic();

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("rc4_stream_cipher regression: pass");
    end else begin
      $display("rc4_stream_cipher regression: fail");
    end
    $finish;
  end

endmodule
